[hw/rtl/crc_chk_pkg.sv]
package crc_chk_pkg;

  // Input commands, carried in s_axis_tuser.
  localparam logic [1:0] CMD_HEADER = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Result kinds, carried in m_axis_tuser.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_PADDING = 2'd1;
  localparam logic [1:0] ERR_PARTIAL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_GEN_BITS = 2'd0;
  localparam logic [1:0] REG_GEN_LEN  = 2'd1;
  localparam logic [1:0] REG_DW_MODE  = 2'd2;

  localparam logic [15:0] GEN_BITS_RESET = 16'd11;
  localparam logic [4:0]  GEN_LEN_RESET  = 5'd4;

  localparam int MAX_GEN_LEN_DEFAULT = 16;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 80;

  typedef struct packed {
    logic [1:0]  error_code;
    logic [31:0] error_total;
    logic [31:0] codeword_total;
    logic [7:0]  decoded_byte;
    logic [1:0]  out_kind;
  } result_t;

endpackage

[hw/rtl/crc_codeword_checker.sv]
// CRC codeword checker. A header beat (tuser = 0) starts a stream and gives in
// tdata how many leading bits to drop (eight or more gives a stream error beat).
// Data beats (tuser = 1) carry stream bytes, MSB first; their bits are cut into
// codewords of D + L - 1 bits, each divided by the generator, and the dataword
// bits are repacked into decoded byte beats. A finish beat (tuser = 2) returns
// the codeword and error counts, or a stream error for a partial codeword.
// A data byte runs through eight unrolled division steps between the state
// registers and a two-entry result queue, so the block takes one beat per clock
// as long as the queue has room; each result is registered in the queue before
// it appears on m_axis.
module crc_codeword_checker
  import crc_chk_pkg::*;
#(
  parameter int MAX_GEN_LEN = MAX_GEN_LEN_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic [1:0]             s_axis_tuser,  // [1:0] command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] decoded_byte, [39:8] codeword_total, [71:40] error_total,
  // [73:72] error_code, [79:74] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic [1:0]             m_axis_tuser   // [1:0] out_kind
);

  localparam int REM_W  = MAX_GEN_LEN - 1;
  localparam int REM_IW = (REM_W > 1) ? $clog2(REM_W) : 1;
  localparam int POS_W  = $clog2(8 + MAX_GEN_LEN);
  localparam int GLEN_W = $clog2(MAX_GEN_LEN + 1);

  // Configuration registers
  logic [15:0] gen_bits;
  logic [4:0]  gen_len;
  logic        dw_mode;

  // Stream state
  logic [2:0]             padding_left;
  logic [REM_W-1:0]       remainder_reg;
  logic [POS_W-1:0]       bit_position;
  logic [7:0]             pack_reg;
  logic [3:0]             pack_count;
  logic [COUNT_WIDTH-1:0] codeword_tally;
  logic [COUNT_WIDTH-1:0] error_tally;

  logic [2:0]             padding_left_next;
  logic [REM_W-1:0]       remainder_reg_next;
  logic [POS_W-1:0]       bit_position_next;
  logic [7:0]             pack_reg_next;
  logic [3:0]             pack_count_next;
  logic [COUNT_WIDTH-1:0] codeword_tally_next;
  logic [COUNT_WIDTH-1:0] error_tally_next;

  // Result queue
  result_t    q0, q1;
  logic [1:0] q_count;
  result_t    res;
  logic       res_valid;

  logic [GLEN_W-1:0] glen;
  logic [REM_IW-1:0] top_idx;
  logic [POS_W-1:0]  cw_len;
  logic [POS_W-1:0]  dw_len;
  logic [REM_W-1:0]  rem_mask;
  logic [REM_W-1:0]  gen_poly;

  logic accept, pop, push;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] t,
                                                     input logic [1:0] k);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, t} + (COUNT_WIDTH+1)'(k);
    if (sum[COUNT_WIDTH]) begin
      return '1;
    end
    return sum[COUNT_WIDTH-1:0];
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push          = accept && res_valid;
  assign s_axis_tready = (q_count != 2'd2);
  assign m_axis_tvalid = (q_count != 2'd0);
  assign m_axis_tuser  = q0.out_kind;
  assign m_axis_tdata  = {6'd0, q0.error_code, q0.error_total, q0.codeword_total,
                          q0.decoded_byte};

  // Effective sizes from the configuration registers.
  always_comb begin
    if (int'(gen_len) < 2) begin
      glen = GLEN_W'(2);
    end else if (int'(gen_len) > MAX_GEN_LEN) begin
      glen = GLEN_W'(MAX_GEN_LEN);
    end else begin
      glen = GLEN_W'(gen_len);
    end
    top_idx = REM_IW'(glen - GLEN_W'(2));
    dw_len  = dw_mode ? POS_W'(8) : POS_W'(4);
    cw_len  = POS_W'(dw_len + POS_W'(glen) - POS_W'(1));
    for (int j = 0; j < REM_W; j++) begin
      rem_mask[j] = (j < int'(glen) - 1);
      gen_poly[j] = (j < 16) ? (gen_bits[j % 16] && rem_mask[j]) : 1'b0;
    end
  end

  // One beat's work.
  always_comb begin
    logic       b;
    logic       top;
    logic       emitted;
    logic [1:0] n_cw, n_err, e_cw, e_err;
    logic [7:0] e_byte;

    padding_left_next   = padding_left;
    remainder_reg_next  = remainder_reg;
    bit_position_next   = bit_position;
    pack_reg_next       = pack_reg;
    pack_count_next     = pack_count;
    codeword_tally_next = codeword_tally;
    error_tally_next    = error_tally;
    res_valid           = 1'b0;
    res.out_kind        = KIND_BYTE;
    res.decoded_byte    = 8'd0;
    res.codeword_total  = 32'(codeword_tally);
    res.error_total     = 32'(error_tally);
    res.error_code      = ERR_NONE;
    b       = 1'b0;
    top     = 1'b0;
    emitted = 1'b0;
    n_cw    = 2'd0;
    n_err   = 2'd0;
    e_cw    = 2'd0;
    e_err   = 2'd0;
    e_byte  = 8'd0;

    case (s_axis_tuser)
      CMD_HEADER: begin
        padding_left_next   = 3'd0;
        remainder_reg_next  = '0;
        bit_position_next   = '0;
        pack_reg_next       = 8'd0;
        pack_count_next     = 4'd0;
        codeword_tally_next = '0;
        error_tally_next    = '0;
        if (s_axis_tdata[7:3] != 5'd0) begin
          res_valid          = 1'b1;
          res.out_kind       = KIND_ERROR;
          res.codeword_total = 32'd0;
          res.error_total    = 32'd0;
          res.error_code     = ERR_PADDING;
        end else begin
          padding_left_next = s_axis_tdata[2:0];
        end
      end
      CMD_FINISH: begin
        res_valid = 1'b1;
        if (bit_position != '0) begin
          res.out_kind   = KIND_ERROR;
          res.error_code = ERR_PARTIAL;
        end else begin
          res.out_kind = KIND_SUMMARY;
        end
        padding_left_next   = 3'd0;
        remainder_reg_next  = '0;
        bit_position_next   = '0;
        pack_reg_next       = 8'd0;
        pack_count_next     = 4'd0;
        codeword_tally_next = '0;
        error_tally_next    = '0;
      end
      CMD_DATA: begin
        for (int i = 7; i >= 0; i--) begin
          b = s_axis_tdata[i];
          if (padding_left_next != 3'd0) begin
            padding_left_next = padding_left_next - 3'd1;
          end else begin
            if (bit_position_next < dw_len) begin
              pack_reg_next = {pack_reg_next[6:0], b};
              if (pack_count_next != 4'd15) begin
                pack_count_next = pack_count_next + 4'd1;
              end
            end
            top = remainder_reg_next[top_idx];
            remainder_reg_next = ((remainder_reg_next << 1) | REM_W'(b)) & rem_mask;
            if (top) begin
              remainder_reg_next = remainder_reg_next ^ gen_poly;
            end
            bit_position_next = bit_position_next + POS_W'(1);
            if (bit_position_next >= cw_len) begin
              n_cw = n_cw + 2'd1;
              if (remainder_reg_next != '0) begin
                n_err = n_err + 2'd1;
              end
              remainder_reg_next = '0;
              bit_position_next  = '0;
              // Only the first packed byte of a beat is sent.
              if (pack_count_next >= 4'd8 && !emitted) begin
                emitted         = 1'b1;
                e_byte          = pack_reg_next;
                e_cw            = n_cw;
                e_err           = n_err;
                pack_reg_next   = 8'd0;
                pack_count_next = 4'd0;
              end
            end
          end
        end
        codeword_tally_next = sat_add(codeword_tally, n_cw);
        error_tally_next    = sat_add(error_tally, n_err);
        res_valid           = emitted;
        res.decoded_byte    = e_byte;
        // The counts reported are those at the moment the byte completed.
        res.codeword_total  = 32'(sat_add(codeword_tally, e_cw));
        res.error_total     = 32'(sat_add(error_tally, e_err));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_bits       <= GEN_BITS_RESET;
      gen_len        <= GEN_LEN_RESET;
      dw_mode        <= 1'b0;
      padding_left   <= 3'd0;
      remainder_reg  <= '0;
      bit_position   <= '0;
      pack_reg       <= 8'd0;
      pack_count     <= 4'd0;
      codeword_tally <= '0;
      error_tally    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GEN_BITS: gen_bits <= cfg_data;
          REG_GEN_LEN:  gen_len  <= cfg_data[4:0];
          REG_DW_MODE:  dw_mode  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        padding_left   <= padding_left_next;
        remainder_reg  <= remainder_reg_next;
        bit_position   <= bit_position_next;
        pack_reg       <= pack_reg_next;
        pack_count     <= pack_count_next;
        codeword_tally <= codeword_tally_next;
        error_tally    <= error_tally_next;
      end
    end
  end

  // Two-entry result queue; q0 is the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else begin
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    logic [1:0] wr_slot;
    wr_slot = q_count - {1'b0, pop};
    if (push && wr_slot == 2'd0) begin
      q0 <= res;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && wr_slot != 2'd0) begin
      q1 <= res;
    end
  end

endmodule
